// ===== sv/ggm_pkg.sv =====
// Package for the grid gradient magnitude unit.
// Holds shared constants, the register indexes and the command codes.
package ggm_pkg;

  localparam int unsigned CfgColsIdx = 0;
  localparam int unsigned CfgRowsIdx = 1;
  localparam int unsigned CfgInvIdx  = 2;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam logic [12:0] ColsReset = 13'd64;
  localparam logic [12:0] RowsReset = 13'd64;
  localparam logic [23:0] InvReset  = 24'd65536;

  localparam logic [28:0] DerivClamp = 29'h1000_0000;
  localparam logic [23:0] OutMax     = 24'hFF_FFFF;

endpackage

// ===== sv/ggm_if.sv =====
// Valid/ready channel interfaces for the grid gradient magnitude unit.
// Depends on nothing.
interface ggm_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [11:0] point_index;
  logic signed [23:0] sample_value;
  modport source (output valid, cmd, point_index, sample_value, input ready);
  modport sink   (input valid, cmd, point_index, sample_value, output ready);
endinterface

interface ggm_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] gradient;
  logic        gradient_valid;
  modport source (output valid, gradient, gradient_valid, input ready);
  modport sink   (input valid, gradient, gradient_valid, output ready);
endinterface

// ===== sv/ggm_isqrt.sv =====
// Iterative floor integer square root, one result bit per cycle.
// Depends on ggm_pkg.
module ggm_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [57:0] radicand_i,
  output logic        done_o,
  output logic [28:0] root_o
);
  import ggm_pkg::*;

  logic [57:0] rem_q, rem_d;
  logic [28:0] root_q, root_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [59:0] trial;
  logic [59:0] remx;

  always_comb begin
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    remx   = {2'b00, rem_q};
    trial  = '0;
    if (start_i) begin
      rem_d  = radicand_i;
      root_d = '0;
      cnt_d  = 5'd28;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // Bit cnt of the root: test (root << (cnt+1)) + (1 << 2cnt) against the remainder.
      trial = (60'(root_q) << (cnt_q + 5'd1)) + (60'd1 << {cnt_q, 1'b0});
      if (remx >= trial) begin
        rem_d  = rem_q - trial[57:0];
        root_d = root_q | (29'd1 << cnt_q);
      end
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;
endmodule

// ===== sv/ggm_cfg.sv =====
// APB-style configuration register file for the grid gradient magnitude unit.
// Depends on ggm_pkg.
module ggm_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [12:0] cols_o,
  output logic [12:0] rows_o,
  output logic [23:0] inv_o
);
  import ggm_pkg::*;

  logic [12:0] cols_q, rows_q;
  logic [23:0] inv_q;
  logic        wr;
  logic [1:0]  idx;

  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= ColsReset;
      rows_q <= RowsReset;
      inv_q  <= InvReset;
    end else if (wr && paddr[1:0] == 2'b00) begin
      case (idx)
        2'(CfgColsIdx): cols_q <= pwdata[12:0];
        2'(CfgRowsIdx): rows_q <= pwdata[12:0];
        2'(CfgInvIdx):  inv_q  <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      2'(CfgColsIdx): prdata = {19'd0, cols_q};
      2'(CfgRowsIdx): prdata = {19'd0, rows_q};
      2'(CfgInvIdx):  prdata = {8'd0, inv_q};
      default:        prdata = '0;
    endcase
  end

  assign cols_o = cols_q;
  assign rows_o = rows_q;
  assign inv_o  = inv_q;
endmodule

// ===== sv/grid_gradient_magnitude_unit.sv =====
// Top level of the grid gradient magnitude unit: grid memory, sequencer, datapath.
// Depends on ggm_pkg, ggm_if, ggm_cfg and ggm_isqrt.
//
// A load request writes one sample into the single-port grid memory and offers its
// zero result through the S_OUT state and the output register. A query request
// divides its index by the column count one quotient bit a cycle, reads two
// neighbors per axis through the one memory port and scales each difference by
// the inverse resolution, then takes a root one bit a cycle, and its result goes
// through S_OUT to the output register. A new request is accepted as soon as the
// sequencer is idle, even while the previous result still waits in the output
// register. The grid memory has no reset and no clearing pass.
module grid_gradient_magnitude_unit #(
  parameter int unsigned MAX_POINTS  = 4096,
  parameter int unsigned SAMPLE_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  ggm_in_if.sink      in_if,
  ggm_out_if.source   out_if
);
  import ggm_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned TW = AW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_RA, S_WA, S_RB, S_WB, S_MUL1, S_MUL2, S_NEXT, S_SQ, S_ROOT,
    S_OUT
  } state_e;

  logic [12:0] cols, rows;
  logic [23:0] inv;

  ggm_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cols_o(cols), .rows_o(rows), .inv_o(inv)
  );

  logic signed [SAMPLE_BITS-1:0] mem [MAX_POINTS];
  logic signed [SAMPLE_BITS-1:0] rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic signed [SAMPLE_BITS-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_addr];
  end

  state_e state_q;
  logic [11:0] idx_q;
  logic [12:0] rem_q;     // column after division
  logic [11:0] quo_q;     // row after division
  logic [3:0]  bit_q;
  logic        axis_q;    // 0 rows, 1 columns
  logic [AW-1:0] addr_a_q, addr_b_q;
  logic        edge_q;
  logic signed [SAMPLE_BITS-1:0] sa_q;
  logic [SAMPLE_BITS:0] mag_q;
  logic [SAMPLE_BITS+24:0] prod_q;
  logic [28:0] dr_q, dc_q;
  logic [57:0] sq_c;
  logic [23:0] grad_q;
  logic        gvalid_q, ovalid_q;
  logic [23:0] out_grad_q;
  logic        out_gvalid_q;
  logic        out_fire;
  logic        sq_start;
  logic        sq_done;
  logic [28:0] root;

  assign sq_c = 58'(dr_q) * 58'(dr_q) + 58'(dc_q) * 58'(dc_q);

  ggm_isqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .radicand_i(sq_c), .done_o(sq_done),
    .root_o(root)
  );

  // Saturate the incoming 24-bit sample to SAMPLE_BITS.
  logic signed [SAMPLE_BITS-1:0] sat_sample;
  always_comb begin
    logic signed [32:0] v, hi, lo;
    v  = 33'(in_if.sample_value);
    hi = (33'sd1 <<< (SAMPLE_BITS - 1)) - 33'sd1;
    lo = -hi - 33'sd1;
    if (v > hi)      sat_sample = hi[SAMPLE_BITS-1:0];
    else if (v < lo) sat_sample = lo[SAMPLE_BITS-1:0];
    else             sat_sample = v[SAMPLE_BITS-1:0];
  end

  logic [25:0] total;
  logic        grid_ok;
  assign total   = 26'(rows) * 26'(cols);
  assign grid_ok = rows >= 13'd2 && cols >= 13'd2 && total <= 26'(MAX_POINTS);

  // Neighbour addresses along the current axis.
  logic [12:0] pos, n;
  logic [TW+12:0] stride, base;
  logic [TW+12:0] ia, ib;
  logic           edge_c;
  always_comb begin
    pos    = axis_q ? rem_q : {1'b0, quo_q};
    n      = axis_q ? cols : rows;
    stride = axis_q ? (TW+13)'(1) : (TW+13)'(cols);
    base   = axis_q ? (TW+13)'(quo_q) * (TW+13)'(cols) : (TW+13)'(rem_q);
    edge_c = 1'b1;
    if (pos != 13'd0 && pos != n - 13'd1) begin
      ia = base + (TW+13)'(pos + 13'd1) * stride;
      ib = base + (TW+13)'(pos - 13'd1) * stride;
      edge_c = 1'b0;
    end else if (pos == 13'd0) begin
      ia = base + stride;
      ib = base;
    end else begin
      ia = base + (TW+13)'(n - 13'd1) * stride;
      ib = base + (TW+13)'(n - 13'd2) * stride;
    end
  end

  logic [12:0] rem_sh;
  assign rem_sh = {rem_q[11:0], idx_q[bit_q]};

  logic                    div_ge;
  logic [SAMPLE_BITS:0]    diff_c;
  logic [SAMPLE_BITS+24:0] shifted;
  logic [28:0]             deriv_c;
  always_comb begin
    div_ge  = rem_sh >= cols;
    diff_c  = (SAMPLE_BITS+1)'(sa_q) - (SAMPLE_BITS+1)'(rdata_q);
    if (sa_q < rdata_q) diff_c = (SAMPLE_BITS+1)'(rdata_q) - (SAMPLE_BITS+1)'(sa_q);
    shifted = prod_q >> (edge_q ? 12 : 13);
    deriv_c = (shifted > (SAMPLE_BITS+25)'(DerivClamp)) ? DerivClamp : shifted[28:0];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = addr_a_q;
    mem_wdata = sat_sample;
    sq_start  = (state_q == S_SQ);
    if (in_if.valid && in_if.ready && in_if.cmd == CmdLoad) begin
      mem_we   = (32'(in_if.point_index) < MAX_POINTS);
      mem_addr = AW'(in_if.point_index);
    end else if (state_q == S_RA) begin
      mem_re = 1'b1;
    end else if (state_q == S_RB) begin
      mem_re = 1'b1;
      mem_addr = addr_b_q;
    end
  end

  assign in_if.ready = (state_q == S_IDLE);
  assign out_fire    = out_if.valid && out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      if (state_q == S_OUT && (!ovalid_q || out_fire)) begin
        ovalid_q     <= 1'b1;
        out_grad_q   <= grad_q;
        out_gvalid_q <= gvalid_q;
      end else if (out_fire) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: if (in_if.valid && in_if.ready) begin
          idx_q <= in_if.point_index;
          if (in_if.cmd == CmdLoad || !grid_ok || 26'(in_if.point_index) >= total) begin
            grad_q <= '0; gvalid_q <= 1'b0; state_q <= S_OUT;
          end else begin
            rem_q <= '0; quo_q <= '0; bit_q <= 4'd11; state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_ge) begin
            rem_q <= rem_sh - cols; quo_q[bit_q] <= 1'b1;
          end else rem_q <= rem_sh;
          if (bit_q == 4'd0) begin axis_q <= 1'b0; state_q <= S_WA; end
          else bit_q <= bit_q - 4'd1;
        end
        S_WA: begin
          addr_a_q <= AW'(ia); addr_b_q <= AW'(ib); edge_q <= edge_c; state_q <= S_RA;
        end
        S_RA: state_q <= S_WB;
        S_WB: begin sa_q <= rdata_q; state_q <= S_RB; end
        S_RB: state_q <= S_MUL1;
        S_MUL1: begin mag_q <= diff_c; state_q <= S_MUL2; end
        S_MUL2: begin prod_q <= (SAMPLE_BITS+25)'(mag_q) * (SAMPLE_BITS+25)'(inv);
          state_q <= S_NEXT; end
        S_NEXT: begin
          if (!axis_q) begin dr_q <= deriv_c; axis_q <= 1'b1; state_q <= S_WA; end
          else begin dc_q <= deriv_c; state_q <= S_SQ; end
        end
        S_SQ: state_q <= S_ROOT;
        S_ROOT: if (sq_done) begin
          grad_q <= (root >> 4) > 29'(OutMax) ? OutMax : 24'(root >> 4);
          gvalid_q <= 1'b1; state_q <= S_OUT;
        end
        S_OUT: if (!ovalid_q || out_fire) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid          = ovalid_q;
  assign out_if.gradient       = out_grad_q;
  assign out_if.gradient_valid = out_gvalid_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |-> state_q == S_IDLE) else $error("accept while busy");
  a_hold_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> out_if.valid && $stable(out_if.gradient))
    else $error("result dropped");
  a_load_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.gradient_valid) |-> out_if.gradient == '0)
    else $error("nonzero invalid result");
endmodule

// ===== sim/grid_gradient_magnitude_unit_tb.sv =====
// Self-checking testbench for grid_gradient_magnitude_unit: loads grid samples, queries
// gradients under several grid shapes and resolutions, and checks every result in order.
// Depends on ggm_pkg, ggm_if and the unit itself.
module grid_gradient_magnitude_unit_tb;
  import ggm_pkg::*;

  typedef struct {
    logic [23:0] gradient;
    logic        gradient_valid;
  } gradient_t;

  class gradient_scoreboard;
    logic signed [23:0] grid [4096];
    bit                 loaded [4096];
    int unsigned        cols = ColsReset;
    int unsigned        rows = RowsReset;
    longint unsigned    inv  = InvReset;
    gradient_t          pending [$];
    int                 errors;
    int                 valid_seen;

    function bit grid_ok(int unsigned idx);
      return rows >= 2 && cols >= 2 && rows * cols <= 4096 && idx < rows * cols;
    endfunction

    function void axis_pair(int unsigned pos, int unsigned n, int unsigned s,
                            int unsigned base, output int unsigned hi, output int unsigned lo,
                            output longint unsigned k);
      if (pos > 0 && pos < n - 1) begin
        hi = base + (pos + 1) * s; lo = base + (pos - 1) * s; k = 1;
      end else if (pos == 0) begin
        hi = base + s; lo = base; k = 2;
      end else begin
        hi = base + (n - 1) * s; lo = base + (n - 2) * s; k = 2;
      end
    endfunction

    function void neighbors(int unsigned idx, output int unsigned lst [4]);
      int unsigned hi, lo;
      longint unsigned k;
      axis_pair(idx / cols, rows, cols, idx % cols, hi, lo, k);
      lst[0] = hi; lst[1] = lo;
      axis_pair(idx % cols, cols, 1, (idx / cols) * cols, hi, lo, k);
      lst[2] = hi; lst[3] = lo;
    endfunction

    function longint unsigned slope(int unsigned pos, int unsigned n, int unsigned s,
                                    int unsigned base);
      int unsigned hi, lo;
      longint unsigned k, mag, q;
      longint d;
      axis_pair(pos, n, s, base, hi, lo, k);
      d = longint'(grid[hi]) - longint'(grid[lo]);
      mag = d < 0 ? -d : d;
      q = (mag * inv * k) >> 13;
      return q > DerivClamp ? DerivClamp : q;
    endfunction

    function longint unsigned root(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note(logic cmd, int unsigned idx, logic signed [23:0] val);
      gradient_t e;
      longint unsigned dr, dc, g;
      e.gradient = '0;
      e.gradient_valid = 1'b0;
      if (cmd == CmdLoad) begin
        grid[idx] = val;
        loaded[idx] = 1'b1;
      end else if (grid_ok(idx)) begin
        dr = slope(idx / cols, rows, cols, idx % cols);
        dc = slope(idx % cols, cols, 1, (idx / cols) * cols);
        g = root(dr * dr + dc * dc) >> 4;
        e.gradient = g > OutMax ? OutMax : g[23:0];
        e.gradient_valid = 1'b1;
      end
      pending.insert(pending.size(), e);
    endfunction

    function void check(logic [23:0] g, logic v);
      gradient_t e;
      if (v) valid_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result gradient %0d valid %0b", $time, g, v);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (g !== e.gradient) begin
        $display("%0t: gradient expected %0d actual %0d", $time, e.gradient, g);
        errors++;
      end
      if (v !== e.gradient_valid) begin
        $display("%0t: gradient_valid expected %0b actual %0b", $time, e.gradient_valid, v);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ggm_in_if  in_bus ();
  ggm_out_if out_bus ();

  grid_gradient_magnitude_unit i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_if (in_bus), .out_if (out_bus)
  );

  gradient_scoreboard sb = new();
  bit quiet;
  bit stall_req;
  int stall_left;
  int n_items, n_loads, n_queries, n_phases;

  always #5 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_bus.valid && out_bus.ready) sb.check(out_bus.gradient,
                                                           out_bus.gradient_valid);
  end

  initial begin
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_req) begin
        stall_req = 1'b0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= quiet || $urandom_range(99) >= 18;
      end
    end
  end

  task automatic send(logic cmd, int unsigned idx, logic signed [23:0] val);
    while (!quiet && $urandom_range(99) < 18) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid <= 1'b1;
    in_bus.cmd <= cmd;
    in_bus.point_index <= idx[11:0];
    in_bus.sample_value <= val;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note(cmd, idx, val);
    n_items++;
    if (cmd == CmdLoad) n_loads++; else n_queries++;
    @(negedge clk_i);
  endtask

  task automatic load(int unsigned idx, logic signed [23:0] val);
    send(CmdLoad, idx, val);
  endtask

  // Loads any neighbor not yet written so that a query never reads an unwritten entry.
  task automatic query(int unsigned idx);
    int unsigned lst [4];
    if (sb.grid_ok(idx)) begin
      sb.neighbors(idx, lst);
      foreach (lst[i]) if (!sb.loaded[lst[i]]) load(lst[i], 24'($urandom()));
    end
    send(CmdQuery, idx, 24'($urandom()));
  endtask

  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic cfg_write(int unsigned idx, int unsigned value);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= 4'(idx * 4); pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      CfgColsIdx: sb.cols = value & 32'h1FFF;
      CfgRowsIdx: sb.rows = value & 32'h1FFF;
      default:    sb.inv = value & 32'hFF_FFFF;
    endcase
  endtask

  task automatic set_grid(int unsigned r, int unsigned c, int unsigned inv);
    drain();
    cfg_write(CfgColsIdx, c);
    cfg_write(CfgRowsIdx, r);
    cfg_write(CfgInvIdx, inv);
    n_phases++;
  endtask

  initial begin
    int unsigned r, c, inv, n;
    in_bus.valid = 1'b0;
    in_bus.cmd = CmdLoad;
    in_bus.point_index = '0;
    in_bus.sample_value = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: saturating corner, far corner, interior, then degenerate grids.
    load(0, 24'sh7FFFFF);
    load(1, -24'sh800000);
    load(64, -24'sh800000);
    query(0);
    load(4095, -24'sh800000);
    query(4095);
    query(130);
    set_grid(64, 64, 0);
    query(130);
    set_grid(1, 64, 24'hFFFFFF);
    query(5);
    set_grid(4096, 4096, 65536);
    query(5);
    set_grid(2, 2048, 24'hFFFFFF);
    query(2048);
    query(4095);
    query(1000);
    set_grid(3, 2, 1);
    query(3);
    query(100);
    set_grid(2, 1, 65536);
    query(0);

    while (n_items < 1200) begin
      case ($urandom_range(9))
        0: begin r = $urandom_range(1, 3); c = $urandom_range(1, 3); end
        1: begin r = 64; c = 64; end
        2: begin r = $urandom_range(2, 2048); c = $urandom_range(2, 4096 / r); end
        3: begin r = $urandom_range(65, 4096); c = $urandom_range(65, 4096); end
        default: begin r = $urandom_range(2, 8); c = $urandom_range(2, 8); end
      endcase
      case ($urandom_range(7))
        0: inv = 0;
        1: inv = 24'hFFFFFF;
        2: inv = 65536;
        default: inv = $urandom_range(24'hFFFFFF);
      endcase
      set_grid(r, c, inv);
      quiet = (n_phases % 7 == 3);
      if (n_phases % 5 == 2) stall_req = 1'b1;
      n = n_items + 100;
      while (n_items < n) begin
        case ($urandom_range(9))
          0, 1: load($urandom_range(r * c > 4096 ? 4095 : r * c - 1), 24'($urandom()));
          2: query($urandom_range(4095));
          default: query($urandom_range(r * c > 4096 ? 4095 : r * c - 1));
        endcase
      end
    end
    quiet = 1'b0;
    drain();

    $display("Covered %0d requests (%0d loads, %0d queries, %0d valid gradients)",
             n_items, n_loads, n_queries, sb.valid_seen);
    $display("over %0d grid settings, with stalls on both sides.", n_phases);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
